### hw/rtl/lis_pkg.sv
`default_nettype none

package lis_pkg;

	localparam int VALUE_W    = 32;
	localparam int LEN_OUT_W  = 7;
	localparam int OUT_DATA_W = 40;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MAX,
		ST_WALK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// Operations of the shared compare unit.
	typedef enum logic [1:0] {
		CMP_LESS_LONGER,
		CMP_LONGER,
		CMP_MATCH
	} cmp_op_t;

endpackage

`default_nettype wire

### hw/rtl/lis_ram.sv
`default_nettype none

module lis_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata_q
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/lis_cmp.sv
`default_nettype none

module lis_cmp #(
	parameter int LEN_W = 7
) (
	input  wire lis_pkg::cmp_op_t              op,
	input  wire logic [lis_pkg::VALUE_W-1:0]   a_val,
	input  wire logic [lis_pkg::VALUE_W-1:0]   b_val,
	input  wire logic [LEN_W-1:0]              a_len,
	input  wire logic [LEN_W-1:0]              b_len,
	output logic                               hit
);

	import lis_pkg::*;

	logic less;
	logic longer;

	assign less   = $signed(a_val) < $signed(b_val);
	assign longer = a_len > b_len;

	always_comb begin
		case (op)
			CMP_LESS_LONGER: hit = less && longer;
			CMP_LONGER:      hit = longer;
			CMP_MATCH:       hit = a_len == b_len;
			default:         hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/longest_increasing_subsequence_top.sv
`default_nettype none

// Channel  Dir  Fields in tdata (low bit up)           tlast       tuser
// s_*      in   value[31:0]                            last        -
// m_*      out  element[31:0], lis_length[38:32], pad  end_of_run  overflow
//
// Each stored element is accepted and then compared with every element already
// stored: the single read port of the element store and the one compare unit
// handle one earlier element per cycle. The item marked last adds two more sweeps
// (maximum search, backward walk) and then a read and a load step per result, held
// back while m_tready is low.
// Reset is asynchronous and clears the sequencer, counts and the output valid flag.
// s_tready is high only while the sequencer is idle; a waiting final result does not
// hold off the next sequence.

module longest_increasing_subsequence_top #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// s_tdata: value[31:0]
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [lis_pkg::VALUE_W-1:0]      s_tdata,
	input  wire logic                             s_tlast,
	// m_tdata: element[31:0], lis_length[38:32], zero[39]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [lis_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                  m_tlast,
	// m_tuser: overflow[0]
	output logic                                  m_tuser
);

	import lis_pkg::*;

	// Address width of the stores and width of counts and lengths, which reach
	// MAX_ITEMS itself.
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int LW = $clog2(MAX_ITEMS + 1);

	state_t state_q, state_d;

	logic [LW-1:0]      count_q;
	logic               dropped_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;
	logic [LW-1:0]      ptr_q;
	logic [LW-1:0]      best_q;
	logic [LW-1:0]      target_q;
	logic [LW-1:0]      total_q;
	logic               rd_valid_s1;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_elem_q;
	logic [LW-1:0]      out_len_q;
	logic               out_last_q;
	logic               out_ovf_q;

	logic               in_acc;
	logic               has_room;
	logic               issue;
	logic               sweep_done;
	logic [LW-1:0]      ptr_m1;
	logic [AW-1:0]      rd_addr;
	logic               store_we;
	logic               res_we;
	logic [LW-1:0]      target_m1;
	logic               out_free;
	logic               emit_last;

	logic [VALUE_W-1:0] val_rd_s1;
	logic [LW-1:0]      len_rd_s1;
	logic [VALUE_W-1:0] res_rd_s1;

	cmp_op_t            cmp_op;
	logic [LW-1:0]      cmp_b_len;
	logic               cmp_hit;
	logic [LW+LEN_OUT_W-1:0] len_ext;

	assign in_acc    = s_tvalid && s_tready;
	assign has_room  = count_q < LW'(MAX_ITEMS);
	assign ptr_m1    = ptr_q - 1'b1;
	assign target_m1 = target_q - 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign emit_last = LW'(ptr_q + 1'b1) == total_q;

	// Element values and their subsequence end lengths share one address.
	lis_ram #(.W(VALUE_W), .DEPTH(MAX_ITEMS)) u_values (
		.clk     (clk),
		.we      (store_we),
		.waddr   (count_q[AW-1:0]),
		.wdata   (value_q),
		.raddr   (rd_addr),
		.rdata_q (val_rd_s1)
	);

	lis_ram #(.W(LW), .DEPTH(MAX_ITEMS)) u_lengths (
		.clk     (clk),
		.we      (store_we),
		.waddr   (count_q[AW-1:0]),
		.wdata   (LW'(best_q + 1'b1)),
		.raddr   (rd_addr),
		.rdata_q (len_rd_s1)
	);

	// The backward walk finds the chosen elements from the last one down, so
	// each is written at its place in the run and read out in index order.
	lis_ram #(.W(VALUE_W), .DEPTH(MAX_ITEMS)) u_results (
		.clk     (clk),
		.we      (res_we),
		.waddr   (target_m1[AW-1:0]),
		.wdata   (val_rd_s1),
		.raddr   (ptr_q[AW-1:0]),
		.rdata_q (res_rd_s1)
	);

	lis_cmp #(.LEN_W(LW)) u_cmp (
		.op    (cmp_op),
		.a_val (val_rd_s1),
		.b_val (value_q),
		.a_len (len_rd_s1),
		.b_len (cmp_b_len),
		.hit   (cmp_hit)
	);

	// Next state, read issue and compare selection.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		issue     = 1'b0;
		rd_addr   = ptr_q[AW-1:0];
		cmp_op    = CMP_LONGER;
		cmp_b_len = best_q;
		store_we  = 1'b0;
		res_we    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (has_room) begin
						state_d = ST_SCAN;
					end else if (s_tlast) begin
						state_d = ST_MAX;
					end
				end
			end
			ST_SCAN: begin
				cmp_op = CMP_LESS_LONGER;
				issue  = ptr_q < count_q;
				if (!issue && !rd_valid_s1) begin
					store_we = 1'b1;
					state_d  = last_q ? ST_MAX : ST_IDLE;
				end
			end
			ST_MAX: begin
				cmp_op = CMP_LONGER;
				issue  = ptr_q < count_q;
				if (!issue && !rd_valid_s1) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmp_op    = CMP_MATCH;
				cmp_b_len = target_q;
				rd_addr   = ptr_m1[AW-1:0];
				issue     = (ptr_q != '0) && (target_q != '0);
				res_we    = rd_valid_s1 && (target_q != '0) && cmp_hit;
				if (!issue && !rd_valid_s1) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				if (out_free) begin
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sweep_done = !issue && !rd_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			ptr_q       <= '0;
			best_q      <= '0;
			target_q    <= '0;
			total_q     <= '0;
			last_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= s_tlast;
						ptr_q  <= '0;
						best_q <= '0;
						if (!has_room) begin
							dropped_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= LW'(ptr_q + 1'b1);
					end
					if (rd_valid_s1 && cmp_hit) begin
						best_q <= len_rd_s1;
					end
					if (sweep_done) begin
						count_q <= LW'(count_q + 1'b1);
						ptr_q   <= '0;
						best_q  <= '0;
					end
				end
				ST_MAX: begin
					if (issue) begin
						ptr_q <= LW'(ptr_q + 1'b1);
					end
					if (rd_valid_s1 && cmp_hit) begin
						best_q <= len_rd_s1;
					end
					if (sweep_done) begin
						ptr_q    <= count_q;
						target_q <= best_q;
						total_q  <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						ptr_q <= ptr_m1;
					end
					if (res_we) begin
						target_q <= target_m1;
						total_q  <= LW'(total_q + 1'b1);
					end
					if (sweep_done) begin
						ptr_q <= '0;
					end
				end
				ST_EMIT_LD: begin
					ptr_q <= LW'(ptr_q + 1'b1);
					if (emit_last) begin
						// The sequence is finished: the next one starts empty.
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input value register, no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_q <= s_tdata;
		end
	end

	// Output register: it holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_LD) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_elem_q <= res_rd_s1;
			out_len_q  <= best_q;
			out_last_q <= emit_last;
			out_ovf_q  <= dropped_q;
		end
	end

	// The reported length keeps its low seven bits.
	assign len_ext  = {{LEN_OUT_W{1'b0}}, out_len_q};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, len_ext[LEN_OUT_W-1:0], out_elem_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

`default_nettype wire

### hw/rtl/lis_checker.sv
`default_nettype none

module lis_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           s_tlast,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [lis_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                           m_tlast,
	input wire logic                           m_tuser
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// The final item of a sequence starts work that blocks the input.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after a final item");

	// While a run is being delivered no new item is taken.
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("input ready in the middle of a run");

	// The padding bit of the result data is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[lis_pkg::OUT_DATA_W-1] == 1'b0)
		else $error("result padding bit set");

endmodule

bind longest_increasing_subsequence_top lis_checker u_lis_checker (.*);

`default_nettype wire

### bench/longest_increasing_subsequence_top_tb.sv
module longest_increasing_subsequence_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lis_pkg::*;

	localparam int LIS_CAPACITY = 64;
	localparam int RANDOM_ITEMS = 300;
	// A cycle budget with no item moving on either side. The slowest stretch is the
	// final item of a full sequence: three sweeps over the store, a sender gap and a
	// receiver stall on top. The limit is several times that.
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 32;
	localparam int N_DIRECTED   = 24;

	// One result item of the block, unpacked from m_tdata, m_tlast and m_tuser.
	typedef struct {
		logic signed [VALUE_W-1:0]   element;
		logic        [LEN_OUT_W-1:0] lis_length;
		logic                        end_of_run;
		logic                        overflow;
	} lis_result_t;

	// One row of the directed stimulus. Rows marked known carry their result.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
		bit                 known;
		lis_result_t        result;
	} stim_row_t;

	// How the values of a random sequence are drawn.
	typedef enum int {
		FILL_ANY,
		FILL_NARROW,
		FILL_RISING,
		FILL_EDGES
	} fill_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VALUE_W-1:0]    s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	longest_increasing_subsequence_top #(
		.MAX_ITEMS(LIS_CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Shadow copy of the sequence held inside the block.
	logic signed [VALUE_W-1:0] held_values [LIS_CAPACITY];
	int                        held_lengths [LIS_CAPACITY];
	int                        held_count = 0;
	bit                        held_dropped = 1'b0;

	// Results that one input item causes, and the results still owed by the block.
	lis_result_t run_results [$];
	lis_result_t lis_expected [$];
	lis_result_t oldest;

	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit steady_sender = 1'b0;

	logic [15:0] stall_pattern = '1;
	logic [3:0]  stall_phase = '0;

	// Works out what one accepted item does to the sequence and which result items
	// it causes. An item past capacity only marks the sequence as overflowed, but a
	// final item still starts the output over what is held.
	task automatic predict_lis(input logic [VALUE_W-1:0] value, input logic last);
		int          best;
		int          target;
		int          total;
		int          emitted;
		bit          chosen [LIS_CAPACITY];
		lis_result_t res;
		run_results.delete();
		foreach (chosen[i])
			chosen[i] = 1'b0;
		if (held_count < LIS_CAPACITY) begin
			best = 0;
			for (int i = 0; i < held_count; i++) begin
				if (held_values[i] < $signed(value) && held_lengths[i] > best)
					best = held_lengths[i];
			end
			held_values[held_count] = value;
			held_lengths[held_count] = best + 1;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			best = 0;
			for (int i = 0; i < held_count; i++) begin
				if (held_lengths[i] > best)
					best = held_lengths[i];
			end
			// Walk backward and keep the newest element of each length.
			target = best;
			total = 0;
			for (int i = held_count - 1; i >= 0 && target > 0; i--) begin
				if (held_lengths[i] == target) begin
					chosen[i] = 1'b1;
					target--;
					total++;
				end
			end
			emitted = 0;
			for (int i = 0; i < held_count; i++) begin
				if (chosen[i]) begin
					res.element = held_values[i];
					res.lis_length = best[LEN_OUT_W-1:0];
					res.end_of_run = (emitted + 1 == total);
					res.overflow = held_dropped;
					run_results.insert(run_results.size(), res);
					emitted++;
				end
			end
			held_count = 0;
			held_dropped = 1'b0;
		end
	endtask

	function automatic stim_row_t row_open(input logic [VALUE_W-1:0] value, input logic last);
		stim_row_t row;
		row.value = value;
		row.last = last;
		row.known = 1'b0;
		row.result = '{'0, '0, 1'b0, 1'b0};
		return row;
	endfunction

	// A sequence of a single item: the result is that item, length one.
	function automatic stim_row_t row_known(input logic [VALUE_W-1:0] value);
		stim_row_t row;
		row.value = value;
		row.last = 1'b1;
		row.known = 1'b1;
		row.result = '{value, 7'd1, 1'b1, 1'b0};
		return row;
	endfunction

	// Offers one item, waits for its handshake and records what it should cause.
	// After a burst of random length the sender drops tvalid for a random gap, except
	// in steady stretches where it keeps the input full.
	task automatic send_item(input stim_row_t row);
		int gap;
		s_tdata <= row.value;
		s_tlast <= row.last;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_lis(row.value, row.last);
		if (row.known)
			lis_expected.insert(lis_expected.size(), row.result);
		else
			foreach (run_results[k])
				lis_expected.insert(lis_expected.size(), run_results[k]);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 8);
			gap = steady_sender ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// The receiver follows a 16-bit ready pattern that is drawn anew each time it
	// wraps: sometimes always ready, sometimes random, sometimes one long stall.
	always @(posedge clk) begin
		if (stall_phase == 4'd15) begin
			case ($urandom_range(0, 3))
				0: begin
					stall_pattern <= '1;
				end
				1: begin
					stall_pattern <= 16'($urandom);
				end
				2: begin
					stall_pattern <= 16'($urandom) | 16'($urandom);
				end
				default: begin
					stall_pattern <= 16'hF00F;
				end
			endcase
		end
		m_tready <= stall_pattern[stall_phase];
		stall_phase <= stall_phase + 4'd1;
	end

	// Every accepted result item is checked against the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (lis_expected.size() == 0) begin
				$error("unexpected result item: element %0d", $signed(m_tdata[VALUE_W-1:0]));
				mismatch_count++;
			end else begin
				oldest = lis_expected.pop_front();
				if ($signed(m_tdata[VALUE_W-1:0]) !== oldest.element) begin
					$error("element: expected %0d, got %0d", oldest.element,
						$signed(m_tdata[VALUE_W-1:0]));
					mismatch_count++;
				end
				if (m_tdata[VALUE_W +: LEN_OUT_W] !== oldest.lis_length) begin
					$error("lis_length: expected %0d, got %0d", oldest.lis_length,
						m_tdata[VALUE_W +: LEN_OUT_W]);
					mismatch_count++;
				end
				if (m_tlast !== oldest.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b", oldest.end_of_run, m_tlast);
					mismatch_count++;
				end
				if (m_tuser !== oldest.overflow) begin
					$error("overflow: expected %0b, got %0b", oldest.overflow, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// The watchdog ends a run in which no item has moved on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t          directed_rows [N_DIRECTED];
		logic [VALUE_W-1:0] value;
		fill_t              fill;
		int                 run_len;
		int                 runs;
		int                 sent;

		// Single items first, straight after reset, then an ascending run across the
		// signed extremes, a falling run where only the newest item survives, a run of
		// equal values (the order is strict) and a mixed run with ties.
		directed_rows = '{
			row_known(32'h8000_0000),
			row_known(32'h7FFF_FFFF),
			row_known(32'h0000_0000),
			row_open(32'h8000_0000, 1'b0),
			row_open(32'hFFFF_FFFF, 1'b0),
			row_open(32'h0000_0000, 1'b0),
			row_open(32'h0000_0001, 1'b0),
			row_open(32'h7FFF_FFFF, 1'b1),
			row_open(32'h7FFF_FFFF, 1'b0),
			row_open(32'h0000_0005, 1'b0),
			row_open(32'hFFFF_FFFB, 1'b0),
			row_open(32'h8000_0000, 1'b1),
			row_open(32'h0000_0007, 1'b0),
			row_open(32'h0000_0007, 1'b0),
			row_open(32'h0000_0007, 1'b1),
			row_open(32'h0000_0003, 1'b0),
			row_open(32'h0000_0001, 1'b0),
			row_open(32'h0000_0004, 1'b0),
			row_open(32'h0000_0001, 1'b0),
			row_open(32'h0000_0005, 1'b0),
			row_open(32'h0000_0009, 1'b0),
			row_open(32'h0000_0002, 1'b0),
			row_open(32'h0000_0006, 1'b0),
			row_open(32'hFFFF_FFFF, 1'b1)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_item(directed_rows[r]);

		// Random sequences, mostly short. The third one fills the store exactly with a
		// rising run, which gives the longest output; the sixth runs past capacity so
		// that its final item is itself dropped.
		runs = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			fill = fill_t'($urandom_range(0, 3));
			if (runs == 2) begin
				run_len = LIS_CAPACITY;
				fill = FILL_RISING;
			end else if (runs == 5) begin
				run_len = LIS_CAPACITY + 3;
			end else begin
				run_len = $urandom_range(1, 12);
			end
			value = 32'h8000_0000 + $urandom_range(0, 1 << 20);
			for (int k = 0; k < run_len; k++) begin
				case (fill)
					FILL_ANY: begin
						value = $urandom;
					end
					FILL_NARROW: begin
						value = int'($urandom_range(0, 12)) - 6;
					end
					FILL_RISING: begin
						// Steps are small enough that 64 of them never wrap.
						if (k > 0)
							value = value + $urandom_range(1, 1 << 24);
					end
					default: begin
						if ($urandom_range(0, 1) == 0)
							value = 32'h8000_0000 + $urandom_range(0, 3);
						else
							value = 32'h7FFF_FFFF - $urandom_range(0, 3);
					end
				endcase
				send_item(row_open(value, k == run_len - 1));
				sent++;
			end
			runs++;
		end

		s_tvalid <= 1'b0;
		while (lis_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
